// ===== design/mlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared record kinds and result types of the measurement line parser.
// ----------------------------------------------------------------------------
package mlp_pkg;

   localparam logic [2:0] KIND_BEGIN    = 3'd0;
   localparam logic [2:0] KIND_END      = 3'd1;
   localparam logic [2:0] KIND_DATA     = 3'd2;
   localparam logic [2:0] KIND_ERROR    = 3'd3;
   localparam logic [2:0] KIND_OVERFLOW = 3'd4;

   typedef struct packed {
      logic [2:0]         record_kind;
      logic [31:0]        timestamp;
      logic [31:0]        adc_code;
      logic [31:0]        voltage_millivolts;
      logic signed [31:0] current_nanoamps;
   } result_type;

   typedef struct packed {
      logic       fire;
      result_type rec;
   } parse_out_type;

endpackage

// ===== design/mlp_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_parse
// Per-byte parser: keeps line state, reports non-empty lines and overflows.
// ----------------------------------------------------------------------------
module mlp_parse #(
   parameter int LINE_CAPACITY = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   output_enable,
   input  logic                   byte_valid,
   input  logic [7:0]             rx_byte,
   output mlp_pkg::parse_out_type parse_out
);

   localparam int LEN_W = $clog2(LINE_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAPACITY - 1);

   localparam logic [2:0] PH_LEAD     = 3'd0;
   localparam logic [2:0] PH_WS       = 3'd1;
   localparam logic [2:0] PH_SIGN     = 3'd2;
   localparam logic [2:0] PH_DIGITS   = 3'd3;
   localparam logic [2:0] PH_DONE     = 3'd4;
   localparam logic [2:0] PH_FAIL     = 3'd5;
   localparam logic [2:0] PH_KW_BEGIN = 3'd6;
   localparam logic [2:0] PH_KW_END   = 3'd7;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_I     = 8'h49;
   localparam logic [7:0] CH_N     = 8'h4E;

   localparam logic [2:0] BEGIN_LEN = 3'd5;
   localparam logic [2:0] END_LEN   = 3'd3;
   localparam logic [1:0] LAST_FIELD = 2'd3;

   function automatic logic [7:0] begin_char(input logic [2:0] idx);
      case (idx)
         3'd0:    begin_char = CH_B;
         3'd1:    begin_char = CH_E;
         3'd2:    begin_char = CH_G;
         3'd3:    begin_char = CH_I;
         default: begin_char = CH_N;
      endcase
   endfunction

   function automatic logic [7:0] end_char(input logic [2:0] idx);
      case (idx)
         3'd0:    end_char = CH_E;
         3'd1:    end_char = CH_N;
         default: end_char = CH_D;
      endcase
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // Phase after a byte where a number may start.
   function automatic logic [2:0] number_phase(input logic [7:0] c);
      if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
         number_phase = PH_WS;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
         number_phase = PH_SIGN;
      end else if (is_digit(c)) begin
         number_phase = PH_DIGITS;
      end else begin
         number_phase = PH_FAIL;
      end
   endfunction

   logic [LEN_W-1:0] len_ff, len_in;
   logic [2:0]       phase_ff, phase_in;
   logic [1:0]       field_ff, field_in;
   logic [2:0]       kw_ff, kw_in;
   logic [32:0]      time_ff, time_in;
   logic [32:0]      adc_ff, adc_in;
   logic [32:0]      volt_ff, volt_in;
   logic [31:0]      cur_ff, cur_in;
   logic             minus_ff, minus_in;
   logic             ended_ff, ended_in;

   // Shared digit and finish unit on the accumulator of the current field.
   logic [32:0] sel_acc;
   logic [32:0] digit_lim;
   logic [35:0] prod;
   logic [32:0] acc_digit;
   logic [32:0] neg_acc;
   logic [32:0] acc_finish;

   always_comb begin
      case (field_ff)
         2'd0:    sel_acc = time_ff;
         2'd1:    sel_acc = adc_ff;
         2'd2:    sel_acc = volt_ff;
         default: sel_acc = {1'b0, cur_ff};
      endcase
      digit_lim = (field_ff == LAST_FIELD) ? 33'h0_8000_0000 : 33'h1_0000_0000;
      prod = ({3'b000, sel_acc} << 3) + ({3'b000, sel_acc} << 1)
           + {32'd0, rx_byte[3:0]};
      acc_digit = (prod > {3'b000, digit_lim}) ? digit_lim : prod[32:0];
      neg_acc = (~sel_acc) + 33'd1;
      if (field_ff == LAST_FIELD) begin
         if (minus_ff) begin
            acc_finish = (sel_acc >= 33'h0_8000_0000) ? 33'h0_8000_0000
                                                      : {1'b0, neg_acc[31:0]};
         end else begin
            acc_finish = (sel_acc > 33'h0_7FFF_FFFF) ? 33'h0_7FFF_FFFF : sel_acc;
         end
      end else begin
         if (sel_acc > 33'h0_FFFF_FFFF) begin
            acc_finish = 33'h0_FFFF_FFFF;
         end else begin
            acc_finish = minus_ff ? {1'b0, neg_acc[31:0]} : sel_acc;
         end
      end
   end

   // Character-level transition of the current line.
   logic       do_digit;
   logic       do_finish;
   logic [2:0] feed_phase;
   logic [1:0] feed_field;
   logic [2:0] feed_kw;
   logic       feed_minus;
   logic [2:0] np;

   always_comb begin
      feed_phase = phase_ff;
      feed_field = field_ff;
      feed_kw    = kw_ff;
      feed_minus = minus_ff;
      do_digit   = 1'b0;
      do_finish  = 1'b0;
      np         = number_phase(rx_byte);
      case (phase_ff)
         PH_LEAD: begin
            if (rx_byte == CH_SPACE || rx_byte == CH_TAB) begin
               feed_phase = PH_LEAD;
            end else if (rx_byte == CH_B) begin
               feed_phase = PH_KW_BEGIN;
               feed_kw    = 3'd1;
            end else if (rx_byte == CH_E) begin
               feed_phase = PH_KW_END;
               feed_kw    = 3'd1;
            end else begin
               feed_phase = np;
               do_digit   = (np == PH_DIGITS);
               if (np == PH_SIGN) begin
                  feed_minus = (rx_byte == CH_MINUS);
               end
            end
         end
         PH_WS: begin
            feed_phase = np;
            do_digit   = (np == PH_DIGITS);
            if (np == PH_SIGN) begin
               feed_minus = (rx_byte == CH_MINUS);
            end
         end
         PH_SIGN: begin
            if (is_digit(rx_byte)) begin
               do_digit   = 1'b1;
               feed_phase = PH_DIGITS;
            end else begin
               feed_phase = PH_FAIL;
            end
         end
         PH_DIGITS: begin
            if (is_digit(rx_byte)) begin
               do_digit = 1'b1;
            end else begin
               do_finish = 1'b1;
               if (field_ff == LAST_FIELD) begin
                  feed_phase = PH_DONE;
               end else if (rx_byte == CH_COMMA) begin
                  feed_field = field_ff + 2'd1;
                  feed_minus = 1'b0;
                  feed_phase = PH_WS;
               end else begin
                  feed_phase = PH_FAIL;
               end
            end
         end
         PH_KW_BEGIN: begin
            if (kw_ff < BEGIN_LEN && rx_byte == begin_char(kw_ff)) begin
               feed_kw = kw_ff + 3'd1;
            end else begin
               feed_phase = PH_FAIL;
            end
         end
         PH_KW_END: begin
            if (kw_ff < END_LEN && rx_byte == end_char(kw_ff)) begin
               feed_kw = kw_ff + 3'd1;
            end else begin
               feed_phase = PH_FAIL;
            end
         end
         default: begin
            feed_phase = phase_ff;
         end
      endcase
   end

   // Line-level step: length, line end, overflow and record.
   logic        is_eol;
   logic        end_finish;
   logic [2:0]  line_kind;
   logic [32:0] acc_new;
   logic        acc_write;

   always_comb begin
      is_eol     = (rx_byte == CH_LF) || (rx_byte == CH_CR);
      end_finish = (phase_ff == PH_DIGITS) && (field_ff == LAST_FIELD);
      if (phase_ff == PH_KW_BEGIN && kw_ff == BEGIN_LEN) begin
         line_kind = mlp_pkg::KIND_BEGIN;
      end else if (phase_ff == PH_KW_END && kw_ff == END_LEN) begin
         line_kind = mlp_pkg::KIND_END;
      end else if (phase_ff == PH_DONE || end_finish) begin
         line_kind = mlp_pkg::KIND_DATA;
      end else begin
         line_kind = mlp_pkg::KIND_ERROR;
      end
      acc_new   = do_digit ? acc_digit : acc_finish;
      acc_write = do_digit || do_finish;

      len_in   = len_ff;
      phase_in = phase_ff;
      field_in = field_ff;
      kw_in    = kw_ff;
      time_in  = time_ff;
      adc_in   = adc_ff;
      volt_in  = volt_ff;
      cur_in   = cur_ff;
      minus_in = minus_ff;
      ended_in = ended_ff;

      parse_out.fire                       = 1'b0;
      parse_out.rec.record_kind            = line_kind;
      parse_out.rec.timestamp              = 32'd0;
      parse_out.rec.adc_code               = 32'd0;
      parse_out.rec.voltage_millivolts     = 32'd0;
      parse_out.rec.current_nanoamps       = 32'sd0;

      if (byte_valid) begin
         if (!is_eol && len_ff != LEN_LAST) begin
            len_in = len_ff + LEN_W'(1);
            if (!ended_ff) begin
               if (rx_byte == CH_NUL) begin
                  ended_in = 1'b1;
               end else begin
                  phase_in = feed_phase;
                  field_in = feed_field;
                  kw_in    = feed_kw;
                  minus_in = feed_minus;
                  if (acc_write) begin
                     case (field_ff)
                        2'd0:    time_in = acc_new;
                        2'd1:    adc_in  = acc_new;
                        2'd2:    volt_in = acc_new;
                        default: cur_in  = acc_new[31:0];
                     endcase
                  end
               end
            end
         end else if (!is_eol || len_ff != '0) begin
            // Overflow or a finished non-empty line: report, then start afresh.
            if (!is_eol) begin
               parse_out.fire            = 1'b1;
               parse_out.rec.record_kind = mlp_pkg::KIND_OVERFLOW;
            end else begin
               parse_out.fire = (line_kind == mlp_pkg::KIND_ERROR) || output_enable;
               if (line_kind == mlp_pkg::KIND_DATA) begin
                  parse_out.rec.timestamp          = time_ff[31:0];
                  parse_out.rec.adc_code           = adc_ff[31:0];
                  parse_out.rec.voltage_millivolts = volt_ff[31:0];
                  parse_out.rec.current_nanoamps   =
                     end_finish ? acc_finish[31:0] : cur_ff;
               end
            end
            len_in   = '0;
            phase_in = PH_LEAD;
            field_in = 2'd0;
            kw_in    = 3'd0;
            time_in  = 33'd0;
            adc_in   = 33'd0;
            volt_in  = 33'd0;
            cur_in   = 32'd0;
            minus_in = 1'b0;
            ended_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         phase_ff <= PH_LEAD;
         field_ff <= 2'd0;
         kw_ff    <= 3'd0;
         time_ff  <= 33'd0;
         adc_ff   <= 33'd0;
         volt_ff  <= 33'd0;
         cur_ff   <= 32'd0;
         minus_ff <= 1'b0;
         ended_ff <= 1'b0;
      end else begin
         len_ff   <= len_in;
         phase_ff <= phase_in;
         field_ff <= field_in;
         kw_ff    <= kw_in;
         time_ff  <= time_in;
         adc_ff   <= adc_in;
         volt_ff  <= volt_in;
         cur_ff   <= cur_in;
         minus_ff <= minus_in;
         ended_ff <= ended_in;
      end
   end

endmodule

// ===== design/measurement_line_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// measurement_line_parser
// Parses received text lines into BEGIN/END markers, four-field data
// records, parse errors and line overflow reports.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_rx_byte
//   rsp      out        rsp_valid/stall    rsp_record_kind, rsp_timestamp,
//                                          rsp_adc_code, rsp_voltage_millivolts,
//                                          rsp_current_nanoamps
//   csr      in         csr_write_enable   csr_write_data (output enable)
//
// One request per cycle unless stalled: each byte is folded into the line
// state in the cycle it is accepted, through one shared multiply-by-ten-and-add
// unit. Records reach rsp from the output register, backed by the skid stage.
// Reset is synchronous and clears the line state, output enable and buffers.
// req_stall rises only when both the output register and the skid stage
// hold records that rsp has not taken.
//
module measurement_line_parser #(
   parameter int LINE_CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_record_kind,
   output logic [31:0]        rsp_timestamp,
   output logic [31:0]        rsp_adc_code,
   output logic [31:0]        rsp_voltage_millivolts,
   output logic signed [31:0] rsp_current_nanoamps,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);

   logic enable_ff;

   // Output register plus skid stage.
   logic                 out_valid_ff, out_valid_in;
   mlp_pkg::result_type  out_rec_ff, out_rec_in;
   logic                 skid_valid_ff, skid_valid_in;
   mlp_pkg::result_type  skid_rec_ff, skid_rec_in;

   logic                   req_accept;
   logic                   rsp_take;
   mlp_pkg::parse_out_type parse_out;

   // Accept whenever the skid stage is free; a new record always has a slot.
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = out_valid_ff && !rsp_stall;

   mlp_parse #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .output_enable (enable_ff),
      .byte_valid    (req_accept),
      .rx_byte       (req_rx_byte),
      .parse_out     (parse_out)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_rec_in    = out_rec_ff;
      skid_valid_in = skid_valid_ff;
      skid_rec_in   = skid_rec_ff;
      // Advance the skid record when the output is taken.
      if (rsp_take) begin
         out_valid_in  = skid_valid_ff;
         out_rec_in    = skid_rec_ff;
         skid_valid_in = 1'b0;
      end
      // Place a new record in the first free slot.
      if (parse_out.fire) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_rec_in   = parse_out.rec;
         end else begin
            skid_valid_in = 1'b1;
            skid_rec_in   = parse_out.rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            enable_ff <= csr_write_data;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers hold without reset.
   always_ff @(posedge clock) begin
      out_rec_ff  <= out_rec_in;
      skid_rec_ff <= skid_rec_in;
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_record_kind        = out_rec_ff.record_kind;
   assign rsp_timestamp          = out_rec_ff.timestamp;
   assign rsp_adc_code           = out_rec_ff.adc_code;
   assign rsp_voltage_millivolts = out_rec_ff.voltage_millivolts;
   assign rsp_current_nanoamps   = out_rec_ff.current_nanoamps;

`ifndef SYNTHESIS
   // The skid stage only fills behind a full output register.
   skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a record while the output is empty");

   // The skid stage fills only when the output was held by the consumer.
   skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid stage filled without a stalled output");

   // Records other than data carry zero numeric fields.
   non_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_kind != mlp_pkg::KIND_DATA) |->
      (rsp_timestamp == 32'd0 && rsp_adc_code == 32'd0 &&
       rsp_voltage_millivolts == 32'd0 && rsp_current_nanoamps == 32'sd0))
      else $error("non-data record with nonzero fields");
`endif

endmodule
